FILE: sv/srm_pkg.sv
`timescale 1ns / 1ps
package srm_pkg;

    // Field widths
    localparam int MAX_CUSTOMERS_DEF = 1024;
    localparam int CW   = 11;   // customer id
    localparam int WW   = 24;   // route load
    localparam int DW   = 16;   // demand
    localparam int OPW  = 2;
    localparam int STW  = 3;
    localparam int CIW  = 2;    // config index
    localparam int IN_TW  = 40;
    localparam int OUT_TW = 72;

    // Opcodes
    localparam logic [OPW-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPW-1:0] OP_OFFER = 2'd1;
    localparam logic [OPW-1:0] OP_QUERY = 2'd2;
    localparam logic [OPW-1:0] OP_NONE  = 2'd3;

    // Result status codes
    localparam logic [STW-1:0] ST_MERGED = 3'd0;
    localparam logic [STW-1:0] ST_SAME   = 3'd1;
    localparam logic [STW-1:0] ST_OVER   = 3'd2;
    localparam logic [STW-1:0] ST_NOJOIN = 3'd3;
    localparam logic [STW-1:0] ST_LOADED = 3'd4;
    localparam logic [STW-1:0] ST_ANSWER = 3'd5;
    localparam logic [STW-1:0] ST_BAD    = 3'd6;

    // Register indexes
    localparam logic [CIW-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CIW-1:0] REG_COUNT    = 2'd1;

    // Memory read address select
    localparam logic [1:0] RS_X  = 2'd0;
    localparam logic [1:0] RS_Q  = 2'd1;
    localparam logic [1:0] RS_RA = 2'd2;
    localparam logic [1:0] RS_A  = 2'd3;

    // Walk pointer source
    localparam logic [1:0] XS_A = 2'd0;
    localparam logic [1:0] XS_B = 2'd1;
    localparam logic [1:0] XS_Q = 2'd2;

    typedef struct packed {
        logic           cap_in;
        logic [1:0]     rd_sel;
        logic           x_ld;
        logic [1:0]     x_sel;
        logic           steps_clr;
        logic           halve_wr;
        logic           ra_ld;
        logic           load_wr;
        logic           cap_a;
        logic           cap_b;
        logic           merge_wr;
        logic           succ_cap;
        logic           out_ld;
        logic           out_bad;
        logic [STW-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic           bad;
        logic [OPW-1:0] op;
        logic           root_found;
        logic           same;
        logic           over;
        logic           can_join;
        logic           out_busy;
    } t_stat;

endpackage

FILE: sv/srm_dp.sv
`timescale 1ns / 1ps
module srm_dp #(
    parameter int MAX_CUSTOMERS = srm_pkg::MAX_CUSTOMERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  srm_pkg::t_cmd          i_cmd,
    output srm_pkg::t_stat         o_stat,
    input  logic [srm_pkg::OPW-1:0] i_op,
    input  logic [srm_pkg::CW-1:0]  i_first_customer,
    input  logic [srm_pkg::CW-1:0]  i_second_customer,
    input  logic [srm_pkg::DW-1:0]  i_demand,
    input  logic [srm_pkg::WW-1:0]  i_capacity,
    input  logic [srm_pkg::CW-1:0]  i_customer_count,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [srm_pkg::STW-1:0] o_status,
    output logic [srm_pkg::CW-1:0]  o_route_root,
    output logic [srm_pkg::CW-1:0]  o_route_head,
    output logic [srm_pkg::CW-1:0]  o_route_tail,
    output logic [srm_pkg::WW-1:0]  o_route_load,
    output logic [srm_pkg::CW-1:0]  o_next_customer
);
    import srm_pkg::*;

    localparam int SLOTS = MAX_CUSTOMERS + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int SW    = $clog2(MAX_CUSTOMERS + 2);

    // Map an id onto a memory slot; ids past the table land on slot zero
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] v);
        logic [AW-1:0] s;
        s = '0;
        if (32'(v) <= 32'(MAX_CUSTOMERS)) begin
            s = AW'(v);
        end
        return s;
    endfunction

    function automatic logic in_range(input logic [CW-1:0] c, input logic [CW-1:0] cnt);
        return (c != '0) && (c <= cnt) && (32'(c) <= 32'(MAX_CUSTOMERS));
    endfunction

    // Route tables
    logic [CW-1:0] m_parent [SLOTS];
    logic [CW-1:0] m_size   [SLOTS];
    logic [CW-1:0] m_first  [SLOTS];
    logic [CW-1:0] m_last   [SLOTS];
    logic [WW-1:0] m_weight [SLOTS];
    logic [CW-1:0] m_succ   [SLOTS];

    logic [CW-1:0] r_q_parent, r_q_size, r_q_first, r_q_last, r_q_succ;
    logic [WW-1:0] r_q_weight;

    logic [OPW-1:0] r_op;
    logic [CW-1:0]  r_a, r_b;
    logic [DW-1:0]  r_d;
    logic [AW-1:0]  r_x, r_ra;
    logic [SW-1:0]  r_steps;
    logic [CW-1:0]  r_sz_a, r_first_a, r_last_a, r_sz_b, r_first_b, r_last_b, r_succ;
    logic [WW-1:0]  r_w_a, r_w_b;

    logic           r_ovalid;
    logic [STW-1:0] r_ostatus;
    logic [CW-1:0]  r_oroot, r_ohead, r_otail, r_onext;
    logic [WW-1:0]  r_oload;

    logic [AW-1:0]  rd_addr, n_x;
    logic [AW-1:0]  a_slot, b_slot, q_slot;
    logic [WW:0]    sum;
    logic           join_ab, join_ba, a_small;
    logic [AW-1:0]  root_slot, other_slot;

    logic           par_we, dat_we, suc_we;
    logic [AW-1:0]  par_wa, dat_wa, suc_wa;
    logic [CW-1:0]  par_wd, size_wd, first_wd, last_wd, suc_wd;
    logic [WW-1:0]  weight_wd;

    assign a_slot = slot_of(r_a);
    assign b_slot = slot_of(r_b);
    assign q_slot = slot_of(r_q_parent);

    // Merge decision from the two captured roots
    assign sum        = {1'b0, r_w_a} + {1'b0, r_w_b};
    assign join_ab    = (r_last_a == r_a) && (r_first_b == r_b);
    assign join_ba    = (r_last_b == r_b) && (r_first_a == r_a);
    assign a_small    = r_sz_a < r_sz_b;
    assign root_slot  = a_small ? r_x : r_ra;
    assign other_slot = a_small ? r_ra : r_x;

    // Status toward the controller
    always_comb begin
        o_stat.bad        = (r_op == OP_NONE) || !in_range(r_a, i_customer_count) ||
                            ((r_op == OP_OFFER) && !in_range(r_b, i_customer_count));
        o_stat.op         = r_op;
        o_stat.root_found = (32'(r_q_parent) == 32'(r_x)) ||
                            (32'(r_steps) > 32'(MAX_CUSTOMERS));
        o_stat.same       = (r_ra == r_x);
        o_stat.over       = sum > {1'b0, i_capacity};
        o_stat.can_join   = join_ab || join_ba;
        o_stat.out_busy   = r_ovalid && !i_m_tready;
    end

    // Read address and walk pointer selection
    always_comb begin
        case (i_cmd.rd_sel)
            RS_Q:    rd_addr = q_slot;
            RS_RA:   rd_addr = r_ra;
            RS_A:    rd_addr = a_slot;
            default: rd_addr = r_x;
        endcase
        case (i_cmd.x_sel)
            XS_B:    n_x = b_slot;
            XS_Q:    n_x = q_slot;
            default: n_x = a_slot;
        endcase
    end

    // Write port selection
    always_comb begin
        par_we    = i_cmd.halve_wr || i_cmd.load_wr || i_cmd.merge_wr;
        dat_we    = i_cmd.load_wr || i_cmd.merge_wr;
        suc_we    = i_cmd.load_wr || i_cmd.merge_wr;
        par_wa    = r_x;
        par_wd    = CW'(q_slot);
        dat_wa    = a_slot;
        size_wd   = CW'(1);
        first_wd  = r_a;
        last_wd   = r_a;
        weight_wd = WW'(r_d);
        suc_wa    = a_slot;
        suc_wd    = '0;
        if (i_cmd.load_wr) begin
            par_wa = a_slot;
            par_wd = r_a;
        end else if (i_cmd.merge_wr) begin
            par_wa    = other_slot;
            par_wd    = CW'(root_slot);
            dat_wa    = root_slot;
            size_wd   = r_sz_a + r_sz_b;
            first_wd  = join_ab ? r_first_a : r_first_b;
            last_wd   = join_ab ? r_last_b : r_last_a;
            weight_wd = sum[WW-1:0];
            suc_wa    = join_ab ? a_slot : b_slot;
            suc_wd    = join_ab ? r_b : r_a;
        end
    end

    // Parent table
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            m_parent[par_wa] <= par_wd;
        end
        r_q_parent <= m_parent[rd_addr];
    end

    // Per-root route data
    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            m_size[dat_wa]   <= size_wd;
            m_first[dat_wa]  <= first_wd;
            m_last[dat_wa]   <= last_wd;
            m_weight[dat_wa] <= weight_wd;
        end
        r_q_size   <= m_size[rd_addr];
        r_q_first  <= m_first[rd_addr];
        r_q_last   <= m_last[rd_addr];
        r_q_weight <= m_weight[rd_addr];
    end

    // Successor list
    always_ff @(posedge i_clk) begin
        if (suc_we) begin
            m_succ[suc_wa] <= suc_wd;
        end
        r_q_succ <= m_succ[rd_addr];
    end

    // Item, walk and capture registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op <= i_op;
            r_a  <= i_first_customer;
            r_b  <= i_second_customer;
            r_d  <= i_demand;
        end
        if (i_cmd.x_ld) begin
            r_x <= n_x;
        end
        if (i_cmd.steps_clr) begin
            r_steps <= '0;
        end else if (i_cmd.halve_wr) begin
            r_steps <= r_steps + SW'(1);
        end
        if (i_cmd.ra_ld) begin
            r_ra <= r_x;
        end
        if (i_cmd.cap_a) begin
            r_sz_a    <= r_q_size;
            r_first_a <= r_q_first;
            r_last_a  <= r_q_last;
            r_w_a     <= r_q_weight;
        end
        if (i_cmd.cap_b) begin
            r_sz_b    <= r_q_size;
            r_first_b <= r_q_first;
            r_last_b  <= r_q_last;
            r_w_b     <= r_q_weight;
        end
        if (i_cmd.succ_cap) begin
            r_succ <= r_q_succ;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_ld) begin
            if (i_cmd.out_bad) begin
                r_ostatus <= ST_BAD;
                r_oroot   <= '0;
                r_ohead   <= '0;
                r_otail   <= '0;
                r_oload   <= '0;
                r_onext   <= '0;
            end else begin
                r_ostatus <= i_cmd.status;
                r_oroot   <= CW'(r_x);
                r_ohead   <= r_first_a;
                r_otail   <= r_last_a;
                r_oload   <= r_w_a;
                r_onext   <= r_succ;
            end
        end
    end

    assign o_m_tvalid      = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_route_root    = r_oroot;
    assign o_route_head    = r_ohead;
    assign o_route_tail    = r_otail;
    assign o_route_load    = r_oload;
    assign o_next_customer = r_onext;

    // A merge joins two distinct roots whose load fits
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_wr |-> (r_ra != r_x) && !o_stat.over && o_stat.can_join)
        else $error("merge of one route or over capacity");

    // A new result never overwrites one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> !r_ovalid || i_m_tready)
        else $error("result overwritten");

    // Halving only happens while the walk has not reached a root
    a_halve_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.halve_wr |-> $past(i_cmd.rd_sel) == RS_Q)
        else $error("halving without parent read");

endmodule

FILE: sv/srm_ctrl.sv
`timescale 1ns / 1ps
module srm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  srm_pkg::t_stat i_stat,
    output srm_pkg::t_cmd  o_cmd
);
    import srm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_LOADW = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FHV   = 4'd5;
    localparam logic [3:0] S_OF1   = 4'd6;
    localparam logic [3:0] S_OF2   = 4'd7;
    localparam logic [3:0] S_OF3   = 4'd8;
    localparam logic [3:0] S_EVAL  = 4'd9;
    localparam logic [3:0] S_RP1   = 4'd10;
    localparam logic [3:0] S_RP2   = 4'd11;
    localparam logic [3:0] S_RP3   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // Which find is running
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    logic [3:0]     r_state, n_state;
    logic [1:0]     r_phase, n_phase;
    logic [STW-1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_R;
            r_status <= ST_BAD;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_status <= n_status;
        end
    end

    // Sequence one item through load, find, merge and report
    always_comb begin
        o_cmd      = '0;
        o_cmd.status = r_status;
        o_s_tready = 1'b0;
        n_state    = r_state;
        n_phase    = r_phase;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.x_sel     = XS_A;
                o_cmd.steps_clr = 1'b1;
                if (i_stat.bad) begin
                    n_status = ST_BAD;
                    n_state  = S_OUT;
                end else if (i_stat.op == OP_LOAD) begin
                    n_status = ST_LOADED;
                    n_state  = S_LOADW;
                end else if (i_stat.op == OP_QUERY) begin
                    o_cmd.x_ld = 1'b1;
                    n_status   = ST_ANSWER;
                    n_phase    = PH_R;
                    n_state    = S_FRD;
                end else begin
                    o_cmd.x_ld = 1'b1;
                    n_phase    = PH_A;
                    n_state    = S_FRD;
                end
            end
            S_LOADW: begin
                o_cmd.load_wr   = 1'b1;
                o_cmd.x_ld      = 1'b1;
                o_cmd.x_sel     = XS_A;
                o_cmd.steps_clr = 1'b1;
                n_phase         = PH_R;
                n_state         = S_FRD;
            end
            S_FRD: begin
                o_cmd.rd_sel = RS_X;
                n_state      = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.root_found) begin
                    unique case (r_phase)
                        PH_A: begin
                            o_cmd.ra_ld     = 1'b1;
                            o_cmd.x_ld      = 1'b1;
                            o_cmd.x_sel     = XS_B;
                            o_cmd.steps_clr = 1'b1;
                            n_phase         = PH_B;
                            n_state         = S_FRD;
                        end
                        PH_B: begin
                            if (i_stat.same) begin
                                o_cmd.x_ld      = 1'b1;
                                o_cmd.x_sel     = XS_A;
                                o_cmd.steps_clr = 1'b1;
                                n_status        = ST_SAME;
                                n_phase         = PH_R;
                                n_state         = S_FRD;
                            end else begin
                                n_state = S_OF1;
                            end
                        end
                        default: begin
                            n_state = S_RP1;
                        end
                    endcase
                end else begin
                    o_cmd.rd_sel = RS_Q;
                    n_state      = S_FHV;
                end
            end
            S_FHV: begin
                o_cmd.halve_wr = 1'b1;
                o_cmd.x_ld     = 1'b1;
                o_cmd.x_sel    = XS_Q;
                n_state        = S_FRD;
            end
            S_OF1: begin
                o_cmd.rd_sel = RS_RA;
                n_state      = S_OF2;
            end
            S_OF2: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = RS_X;
                n_state      = S_OF3;
            end
            S_OF3: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.over) begin
                    n_status = ST_OVER;
                end else if (i_stat.can_join) begin
                    o_cmd.merge_wr = 1'b1;
                    n_status       = ST_MERGED;
                end else begin
                    n_status = ST_NOJOIN;
                end
                o_cmd.x_ld      = 1'b1;
                o_cmd.x_sel     = XS_A;
                o_cmd.steps_clr = 1'b1;
                n_phase         = PH_R;
                n_state         = S_FRD;
            end
            S_RP1: begin
                o_cmd.rd_sel = RS_X;
                n_state      = S_RP2;
            end
            S_RP2: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = RS_A;
                n_state      = S_RP3;
            end
            S_RP3: begin
                o_cmd.succ_cap = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_bad = (r_status == ST_BAD);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/savings_route_merger_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Transfer when        | Payload
// s        | in        | tvalid & tready      | op, first_customer, second_customer, demand
// m        | out       | tvalid & tready      | status, route_root/head/tail/load, next_customer
// cfg      | in        | cfg_valid & cfg_ready| register index, write data
//
// One item at a time. A bad index or unused op goes straight to the result; a load
// writes its entry, then finds its root; a query finds the root of first_customer;
// an offer finds both roots, merges distinct roots when it may, then finds the root
// of first_customer again. Each memory access goes through the registered table read port.
// Reset clears the controller, output valid and config registers; tables fill as loaded.
// A stalled result holds in the output register while the next item is taken.
module savings_route_merger_unit #(
    parameter int MAX_CUSTOMERS = srm_pkg::MAX_CUSTOMERS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [1:0] op, [12:2] first_customer, [23:13] second_customer, [39:24] demand
    input  logic [srm_pkg::IN_TW-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [2:0] status, [13:3] route_root, [24:14] route_head, [35:25] route_tail,
    // [59:36] route_load, [70:60] next_customer, [71] zero
    output logic [srm_pkg::OUT_TW-1:0] o_m_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [srm_pkg::CIW-1:0]    i_cfg_index,
    input  logic [srm_pkg::WW-1:0]     i_cfg_data
);
    import srm_pkg::*;

    logic [WW-1:0]  r_capacity;
    logic [CW-1:0]  r_customer_count;
    t_cmd           cmd;
    t_stat          stat;
    logic [STW-1:0] status;
    logic [CW-1:0]  route_root, route_head, route_tail, next_customer;
    logic [WW-1:0]  route_load;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity       <= '0;
            r_customer_count <= CW'(1024);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CAPACITY: r_capacity       <= i_cfg_data;
                REG_COUNT:    r_customer_count <= i_cfg_data[CW-1:0];
                default:      ;
            endcase
        end
    end

    srm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srm_dp #(
        .MAX_CUSTOMERS (MAX_CUSTOMERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_s_tdata[1:0]),
        .i_first_customer  (i_s_tdata[12:2]),
        .i_second_customer (i_s_tdata[23:13]),
        .i_demand          (i_s_tdata[39:24]),
        .i_capacity        (r_capacity),
        .i_customer_count  (r_customer_count),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_status          (status),
        .o_route_root      (route_root),
        .o_route_head      (route_head),
        .o_route_tail      (route_tail),
        .o_route_load      (route_load),
        .o_next_customer   (next_customer)
    );

    // Pack result fields, lowest first
    assign o_m_tdata = {1'b0, next_customer, route_load, route_tail, route_head,
                        route_root, status};

endmodule
